[rtl/slps_pkg.sv]
// ----------------------------------------------------------------------------
// slps_pkg
// shared types, codes and tables of the status lamp pattern sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package slps_pkg;

	localparam int TICK_COUNT_BITS_DEF = 12;
	localparam int CFG_INDEX_BITS      = 3;
	localparam int CFG_DATA_BITS       = 12;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_FULL_THRESHOLD     = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MID_THRESHOLD      = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_THRESHOLD      = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BATTERY_STEP_TICKS = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CHECK_STEP_TICKS   = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TRIPLE_STEP_TICKS  = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SINGLE_ON_TICKS    = 3'd6;

	// register reset values
	localparam logic [6:0]  FULL_THRESHOLD_RST     = 7'd90;
	localparam logic [6:0]  MID_THRESHOLD_RST      = 7'd50;
	localparam logic [6:0]  LOW_THRESHOLD_RST      = 7'd20;
	localparam logic [11:0] BATTERY_STEP_TICKS_RST = 12'd250;
	localparam logic [11:0] CHECK_STEP_TICKS_RST   = 12'd500;
	localparam logic [11:0] TRIPLE_STEP_TICKS_RST  = 12'd120;
	localparam logic [11:0] SINGLE_ON_TICKS_RST    = 12'd350;

	// command codes
	localparam logic [7:0] CMD_BATTERY      = 8'd0;
	localparam logic [7:0] CMD_CHECK        = 8'd1;
	localparam logic [7:0] CMD_TRIPLE_WHITE = 8'd2;
	localparam logic [7:0] CMD_TRIPLE_GREEN = 8'd3;
	localparam logic [7:0] CMD_SINGLE_GREEN = 8'd4;
	localparam logic [7:0] CMD_SINGLE_BLUE  = 8'd5;

	// last step index of each counted pattern
	localparam logic [3:0] BATTERY_LAST_STEP = 4'd12;
	localparam logic [3:0] TRIPLE_LAST_STEP  = 4'd6;
	localparam logic [3:0] CHECK_LAST_STEP   = 4'd7;

	typedef enum logic [2:0] {
		KIND_NONE    = 3'd0,
		KIND_BATTERY = 3'd1,
		KIND_CHECK   = 3'd2,
		KIND_TRIPLE  = 3'd3,
		KIND_SINGLE  = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		COL_OFF    = 3'd0,
		COL_RED    = 3'd1,
		COL_GREEN  = 3'd2,
		COL_BLUE   = 3'd3,
		COL_YELLOW = 3'd4,
		COL_CYAN   = 3'd5,
		COL_PURPLE = 3'd6,
		COL_WHITE  = 3'd7
	} color_t;

	typedef struct packed {
		logic [6:0]  full_threshold;
		logic [6:0]  mid_threshold;
		logic [6:0]  low_threshold;
		logic [11:0] battery_step_ticks;
		logic [11:0] check_step_ticks;
		logic [11:0] triple_step_ticks;
		logic [11:0] single_on_ticks;
	} cfg_t;

	typedef struct packed {
		kind_t      kind;
		color_t     color;
		logic [3:0] step;
	} pattern_t;

	typedef struct packed {
		logic red_on;
		logic green_on;
		logic blue_on;
		logic busy;
	} result_t;

	// lamp bits {blue, green, red} of a colour
	function automatic logic [2:0] lamp_bits(input color_t c);
		logic [2:0] b;
		case (c)
			COL_RED:    b = 3'b001;
			COL_GREEN:  b = 3'b010;
			COL_BLUE:   b = 3'b100;
			COL_YELLOW: b = 3'b011;
			COL_CYAN:   b = 3'b110;
			COL_PURPLE: b = 3'b101;
			COL_WHITE:  b = 3'b111;
			default:    b = 3'b000;
		endcase
		return b;
	endfunction

	// lamp check colour list, indexed by step 1..7
	function automatic color_t check_color(input logic [3:0] step);
		color_t c;
		case (step)
			4'd1:    c = COL_WHITE;
			4'd2:    c = COL_RED;
			4'd3:    c = COL_GREEN;
			4'd4:    c = COL_BLUE;
			4'd5:    c = COL_YELLOW;
			4'd6:    c = COL_CYAN;
			4'd7:    c = COL_PURPLE;
			default: c = COL_OFF;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

[rtl/slps_cfg.sv]
// ----------------------------------------------------------------------------
// slps_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
`default_nettype none

module slps_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [slps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [slps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output slps_pkg::cfg_t                           cfg
);
	import slps_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_threshold     <= FULL_THRESHOLD_RST;
			cfg_q.mid_threshold      <= MID_THRESHOLD_RST;
			cfg_q.low_threshold      <= LOW_THRESHOLD_RST;
			cfg_q.battery_step_ticks <= BATTERY_STEP_TICKS_RST;
			cfg_q.check_step_ticks   <= CHECK_STEP_TICKS_RST;
			cfg_q.triple_step_ticks  <= TRIPLE_STEP_TICKS_RST;
			cfg_q.single_on_ticks    <= SINGLE_ON_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FULL_THRESHOLD:     cfg_q.full_threshold     <= cfg_data[6:0];
				REG_MID_THRESHOLD:      cfg_q.mid_threshold      <= cfg_data[6:0];
				REG_LOW_THRESHOLD:      cfg_q.low_threshold      <= cfg_data[6:0];
				REG_BATTERY_STEP_TICKS: cfg_q.battery_step_ticks <= cfg_data;
				REG_CHECK_STEP_TICKS:   cfg_q.check_step_ticks   <= cfg_data;
				REG_TRIPLE_STEP_TICKS:  cfg_q.triple_step_ticks  <= cfg_data;
				REG_SINGLE_ON_TICKS:    cfg_q.single_on_ticks    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/slps_step.sv]
// ----------------------------------------------------------------------------
// slps_step
// next pattern state and lamp result for one request
// ----------------------------------------------------------------------------
`default_nettype none

module slps_step #(
	parameter int TICK_COUNT_BITS = slps_pkg::TICK_COUNT_BITS_DEF
) (
	input  wire logic                       mode,
	input  wire logic [7:0]                 command,
	input  wire logic [6:0]                 battery_percent,
	input  wire slps_pkg::cfg_t             cfg,
	input  wire slps_pkg::pattern_t         cur,
	input  wire logic [TICK_COUNT_BITS-1:0] cur_ticks,
	output slps_pkg::pattern_t              nxt,
	output logic [TICK_COUNT_BITS-1:0]      nxt_ticks,
	output slps_pkg::result_t               res
);
	import slps_pkg::*;

	localparam logic [31:0] TICK_MAX =
		32'((64'd1 << TICK_COUNT_BITS) - 64'd1);
	localparam logic [TICK_COUNT_BITS-1:0] TICK_ONE = TICK_COUNT_BITS'(1);

	// step time saturated to the counter width
	function automatic logic [TICK_COUNT_BITS-1:0] sat_ticks(input logic [11:0] v);
		logic [31:0] w;
		w = {20'd0, v};
		return (w > TICK_MAX) ? TICK_MAX[TICK_COUNT_BITS-1:0] : w[TICK_COUNT_BITS-1:0];
	endfunction

	color_t     charge_color;
	logic [3:0] last_step;
	color_t     shown;
	logic [2:0] lamps;

	always_comb begin
		if (battery_percent >= cfg.full_threshold) begin
			charge_color = COL_BLUE;
		end else if (battery_percent >= cfg.mid_threshold) begin
			charge_color = COL_GREEN;
		end else if (battery_percent >= cfg.low_threshold) begin
			charge_color = COL_YELLOW;
		end else begin
			charge_color = COL_RED;
		end
	end

	assign last_step = (cur.kind == KIND_BATTERY) ? BATTERY_LAST_STEP : TRIPLE_LAST_STEP;

	always_comb begin
		nxt       = cur;
		nxt_ticks = cur_ticks;
		if (mode) begin
			// press: restart at the first step
			nxt.step = 4'd1;
			unique case (command)
				CMD_BATTERY: begin
					nxt.kind  = KIND_BATTERY;
					nxt.color = charge_color;
					nxt_ticks = sat_ticks(cfg.battery_step_ticks);
				end
				CMD_CHECK: begin
					nxt.kind  = KIND_CHECK;
					nxt.color = COL_WHITE;
					nxt_ticks = sat_ticks(cfg.check_step_ticks);
				end
				CMD_TRIPLE_WHITE: begin
					nxt.kind  = KIND_TRIPLE;
					nxt.color = COL_WHITE;
					nxt_ticks = sat_ticks(cfg.triple_step_ticks);
				end
				CMD_TRIPLE_GREEN: begin
					nxt.kind  = KIND_TRIPLE;
					nxt.color = COL_GREEN;
					nxt_ticks = sat_ticks(cfg.triple_step_ticks);
				end
				CMD_SINGLE_GREEN: begin
					nxt.kind  = KIND_SINGLE;
					nxt.color = COL_GREEN;
					nxt_ticks = sat_ticks(cfg.single_on_ticks);
				end
				CMD_SINGLE_BLUE: begin
					nxt.kind  = KIND_SINGLE;
					nxt.color = COL_BLUE;
					nxt_ticks = sat_ticks(cfg.single_on_ticks);
				end
				default: begin
					nxt.kind  = KIND_SINGLE;
					nxt.color = COL_RED;
					nxt_ticks = sat_ticks(cfg.single_on_ticks);
				end
			endcase
		end else if (cur.kind != KIND_NONE) begin
			if (cur_ticks <= TICK_ONE) begin
				// step time ran out, take the next step or end the pattern
				nxt_ticks = '0;
				unique case (cur.kind)
					KIND_BATTERY, KIND_TRIPLE: begin
						if (cur.step >= last_step) begin
							nxt.kind = KIND_NONE;
						end else begin
							nxt.step  = cur.step + 4'd1;
							nxt_ticks = (cur.kind == KIND_BATTERY) ?
								sat_ticks(cfg.battery_step_ticks) :
								sat_ticks(cfg.triple_step_ticks);
						end
					end
					KIND_CHECK: begin
						if (cur.step >= CHECK_LAST_STEP) begin
							nxt.kind = KIND_NONE;
						end else begin
							nxt.step  = cur.step + 4'd1;
							nxt_ticks = sat_ticks(cfg.check_step_ticks);
						end
					end
					KIND_SINGLE: begin
						if (cur.step == 4'd0) begin
							nxt.step  = 4'd1;
							nxt_ticks = sat_ticks(cfg.single_on_ticks);
						end else begin
							nxt.kind = KIND_NONE;
						end
					end
					default: begin
						nxt.kind = KIND_NONE;
					end
				endcase
			end else begin
				nxt_ticks = cur_ticks - TICK_ONE;
			end
		end
	end

	// colour shown by the updated state
	always_comb begin
		case (nxt.kind)
			KIND_BATTERY, KIND_TRIPLE: shown = nxt.step[0] ? nxt.color : COL_OFF;
			KIND_CHECK:                shown = check_color(nxt.step);
			KIND_SINGLE:               shown = (nxt.step == 4'd1) ? nxt.color : COL_OFF;
			default:                   shown = COL_OFF;
		endcase
	end

	assign lamps = lamp_bits(shown);

	always_comb begin
		res.red_on   = lamps[0];
		res.green_on = lamps[1];
		res.blue_on  = lamps[2];
		res.busy     = (nxt.kind != KIND_NONE);
	end

endmodule

`default_nettype wire

[rtl/status_led_pattern_sequencer.sv]
// ----------------------------------------------------------------------------
// status_led_pattern_sequencer
// timed rgb status lamp patterns driven by press and millisecond tick requests
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  -------   ---------------------   ----------------------------------------
//  in        in_valid / in_stall     mode, command, battery_percent
//  out       out_valid / out_stall   red_on, green_on, blue_on, busy_res
//  cfg       cfg_we                  cfg_index, cfg_data
//
//  a request waits in the input register until the result register is free, and
//  the step logic writes the result as it leaves; one request per cycle is
//  sustained while no result stalls; the pattern state updates as a request
//  leaves the input register, so the next one sees it in the following cycle
//  reset clears both pipeline valids and the pattern state, and loads the
//  register defaults; a stalled result holds and backs up into in_stall
//
`default_nettype none

module status_led_pattern_sequencer #(
	parameter int TICK_COUNT_BITS = slps_pkg::TICK_COUNT_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// request channel
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                mode,
	input  wire logic [7:0]                          command,
	input  wire logic [6:0]                          battery_percent,
	// result channel
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     red_on,
	output logic                                     green_on,
	output logic                                     blue_on,
	output logic                                     busy_res,
	// configuration writes
	input  wire logic                                cfg_we,
	input  wire logic [slps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [slps_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import slps_pkg::*;

	// input register
	logic       valid_s1;
	logic       mode_s1;
	logic [7:0] command_s1;
	logic [6:0] percent_s1;

	// pattern state
	pattern_t                   pat_q;
	logic [TICK_COUNT_BITS-1:0] ticks_q;

	// result register
	logic    out_valid_q;
	result_t res_q;

	cfg_t                       cfg;
	pattern_t                   pat_nxt;
	logic [TICK_COUNT_BITS-1:0] ticks_nxt;
	result_t                    res_nxt;
	logic                       res_free;
	logic                       move_s1;
	logic                       take_in;

	// result register can take a new value when empty or being drained
	assign res_free = !out_valid_q || !out_stall;
	assign move_s1  = valid_s1 && res_free;
	assign in_stall = valid_s1 && !res_free;
	assign take_in  = in_valid && !in_stall;

	slps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	slps_step #(
		.TICK_COUNT_BITS (TICK_COUNT_BITS)
	) u_step (
		.mode            (mode_s1),
		.command         (command_s1),
		.battery_percent (percent_s1),
		.cfg             (cfg),
		.cur             (pat_q),
		.cur_ticks       (ticks_q),
		.nxt             (pat_nxt),
		.nxt_ticks       (ticks_nxt),
		.res             (res_nxt)
	);

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (take_in) begin
			mode_s1    <= mode;
			command_s1 <= command;
			percent_s1 <= battery_percent;
		end
	end

	// pattern state commits as the request moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q.kind  <= KIND_NONE;
			pat_q.color <= COL_OFF;
			pat_q.step  <= 4'd0;
			ticks_q     <= '0;
		end else if (move_s1) begin
			pat_q   <= pat_nxt;
			ticks_q <= ticks_nxt;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (move_s1) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign red_on    = res_q.red_on;
	assign green_on  = res_q.green_on;
	assign blue_on   = res_q.blue_on;
	assign busy_res  = res_q.busy;

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the status lamp pattern sequencer: a scoreboard
// class tracks the pattern state per accepted request and compares every
// lamp result in order, while tasks drive presses, ticks and register writes
// ----------------------------------------------------------------------------

import slps_pkg::*;

class lamp_scoreboard;
	// pattern state as it stands after the last accepted request
	kind_t       kind;
	color_t      color;
	logic [3:0]  step;
	logic [11:0] ticks_left;
	// register copy
	logic [6:0]  full_th;
	logic [6:0]  mid_th;
	logic [6:0]  low_th;
	logic [11:0] battery_ticks;
	logic [11:0] check_ticks;
	logic [11:0] triple_ticks;
	logic [11:0] single_ticks;
	color_t      check_order[7];
	result_t     lamps_due[$];
	int          mismatches;
	int          checked;
	int          requests;

	function new();
		full_th       = FULL_THRESHOLD_RST;
		mid_th        = MID_THRESHOLD_RST;
		low_th        = LOW_THRESHOLD_RST;
		battery_ticks = BATTERY_STEP_TICKS_RST;
		check_ticks   = CHECK_STEP_TICKS_RST;
		triple_ticks  = TRIPLE_STEP_TICKS_RST;
		single_ticks  = SINGLE_ON_TICKS_RST;
		check_order   = '{COL_WHITE, COL_RED, COL_GREEN, COL_BLUE,
			COL_YELLOW, COL_CYAN, COL_PURPLE};
		kind          = KIND_NONE;
		color         = COL_OFF;
		step          = '0;
		ticks_left    = '0;
	endfunction

	function void flag(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s", what);
	endfunction

	function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
		case (idx)
			REG_FULL_THRESHOLD:     full_th = val[6:0];
			REG_MID_THRESHOLD:      mid_th = val[6:0];
			REG_LOW_THRESHOLD:      low_th = val[6:0];
			REG_BATTERY_STEP_TICKS: battery_ticks = val;
			REG_CHECK_STEP_TICKS:   check_ticks = val;
			REG_TRIPLE_STEP_TICKS:  triple_ticks = val;
			REG_SINGLE_ON_TICKS:    single_ticks = val;
			default: ;
		endcase
	endfunction

	function void end_pattern();
		kind       = KIND_NONE;
		ticks_left = '0;
	endfunction

	// a zero step time simply runs out on the next tick
	function void next_step();
		case (kind)
			KIND_BATTERY: begin
				if (step >= BATTERY_LAST_STEP) end_pattern();
				else begin
					step       = step + 4'd1;
					ticks_left = battery_ticks;
				end
			end
			KIND_TRIPLE: begin
				if (step >= TRIPLE_LAST_STEP) end_pattern();
				else begin
					step       = step + 4'd1;
					ticks_left = triple_ticks;
				end
			end
			KIND_CHECK: begin
				if (step >= CHECK_LAST_STEP) end_pattern();
				else begin
					step       = step + 4'd1;
					ticks_left = check_ticks;
				end
			end
			KIND_SINGLE: begin
				if (step == 4'd0) begin
					step       = 4'd1;
					ticks_left = single_ticks;
				end else
					end_pattern();
			end
			default: end_pattern();
		endcase
	endfunction

	function void launch(kind_t k, color_t c);
		kind       = k;
		color      = c;
		step       = '0;
		ticks_left = '0;
		next_step();
	endfunction

	function color_t lit_color();
		case (kind)
			KIND_BATTERY, KIND_TRIPLE: return step[0] ? color : COL_OFF;
			KIND_CHECK: begin
				if (step >= 4'd1 && step <= 4'd7)
					return check_order[step - 4'd1];
				return COL_OFF;
			end
			KIND_SINGLE: return (step == 4'd1) ? color : COL_OFF;
			default: return COL_OFF;
		endcase
	endfunction

	function void take_request(logic m, logic [7:0] cmd, logic [6:0] pct);
		result_t r;
		color_t  c;
		requests++;
		if (m) begin
			case (cmd)
				CMD_BATTERY: begin
					// thresholds are tried full, mid, low whatever their order
					if (pct >= full_th)     c = COL_BLUE;
					else if (pct >= mid_th) c = COL_GREEN;
					else if (pct >= low_th) c = COL_YELLOW;
					else                    c = COL_RED;
					launch(KIND_BATTERY, c);
				end
				CMD_CHECK:        launch(KIND_CHECK, COL_WHITE);
				CMD_TRIPLE_WHITE: launch(KIND_TRIPLE, COL_WHITE);
				CMD_TRIPLE_GREEN: launch(KIND_TRIPLE, COL_GREEN);
				CMD_SINGLE_GREEN: launch(KIND_SINGLE, COL_GREEN);
				CMD_SINGLE_BLUE:  launch(KIND_SINGLE, COL_BLUE);
				default:          launch(KIND_SINGLE, COL_RED);
			endcase
		end else if (kind != KIND_NONE) begin
			if (ticks_left <= 12'd1) begin
				ticks_left = '0;
				next_step();
			end else
				ticks_left = ticks_left - 12'd1;
		end
		c          = lit_color();
		r.red_on   = c inside {COL_RED, COL_YELLOW, COL_PURPLE, COL_WHITE};
		r.green_on = c inside {COL_GREEN, COL_YELLOW, COL_CYAN, COL_WHITE};
		r.blue_on  = c inside {COL_BLUE, COL_CYAN, COL_PURPLE, COL_WHITE};
		r.busy     = (kind != KIND_NONE);
		lamps_due.push_back(r);
	endfunction

	function void check_lamps(logic r, logic g, logic b, logic busy);
		result_t got;
		result_t want;
		string   names[4];
		names = '{"red_on", "green_on", "blue_on", "busy_res"};
		got   = {r, g, b, busy};
		if (lamps_due.size() == 0) begin
			flag($sformatf("result %b with no request pending", got));
			return;
		end
		want = lamps_due.pop_front();
		checked++;
		for (int f = 0; f < 4; f++)
			if (got[3-f] !== want[3-f])
				flag($sformatf("result %0d %s expected %b got %b", checked, names[f],
					want[3-f], got[3-f]));
	endfunction

	function void finish_check();
		if (lamps_due.size() != 0)
			flag($sformatf("%0d results never arrived", lamps_due.size()));
	endfunction
endclass

module tb;

	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 60;
	localparam logic [7:0] CMD_OTHER_LOW  = 8'd6;
	localparam logic [7:0] CMD_OTHER_HIGH = 8'hFF;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic                      mode;
	logic [7:0]                command;
	logic [6:0]                battery_percent;
	logic                      out_valid;
	logic                      out_stall;
	logic                      red_on;
	logic                      green_on;
	logic                      blue_on;
	logic                      busy_res;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	lamp_scoreboard sb = new();

	bit quiet;          // last part of the run: no idling on either side
	bit idle_on;        // random gaps on the request side in this phase
	bit hold_off_now;   // asks the result side for one long hold-off
	int idle_cycles;
	int sent;
	int settings_used;

	status_led_pattern_sequencer i_dut (.*);

	// free-running clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// accepted requests feed the predictor, accepted results get checked;
	// both sample the values that stood before the edge
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			sb.take_request(mode, command, battery_percent);
		if (out_valid && !out_stall)
			sb.check_lamps(red_on, green_on, blue_on, busy_res);
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	// result side: random stall bursts, plus one long hold-off on request
	initial begin
		int burst;
		int hold;
		burst = 0;
		hold  = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_now) begin
				hold_off_now = 1'b0;
				hold         = HOLD_CYCLES;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else if (burst > 0) begin
				out_stall <= 1'b1;
				burst--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				// start a burst: this stall is its first, burst counts the rest
				burst = $urandom_range(1, 5) - 1;
				out_stall <= 1'b1;
			end else
				out_stall <= 1'b0;
		end
	end

	// one request; valid stays up after acceptance unless a gap follows
	task automatic send_request(input logic m, input logic [7:0] cmd, input logic [6:0] pct);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid        <= 1'b1;
		mode            <= m;
		command         <= cmd;
		battery_percent <= pct;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
	endtask

	task automatic press(input logic [7:0] cmd, input logic [6:0] pct);
		send_request(1'b1, cmd, pct);
	endtask

	// millisecond tick; command and percent carry junk that must be ignored
	task automatic tick();
		send_request(1'b0, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 100)));
	endtask

	// stop offering and wait until every expected result has come back
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.lamps_due.size() != 0) @(posedge clk);
	endtask

	// write all seven registers, one per cycle, while the block is idle
	task automatic write_settings(input int full, input int mid, input int low,
		input int bt, input int ct, input int tt, input int st);
		logic [CFG_INDEX_BITS-1:0] idx[7];
		logic [CFG_DATA_BITS-1:0]  val[7];
		idx = '{REG_FULL_THRESHOLD, REG_MID_THRESHOLD, REG_LOW_THRESHOLD,
			REG_BATTERY_STEP_TICKS, REG_CHECK_STEP_TICKS, REG_TRIPLE_STEP_TICKS,
			REG_SINGLE_ON_TICKS};
		val = '{CFG_DATA_BITS'(full), CFG_DATA_BITS'(mid), CFG_DATA_BITS'(low),
			CFG_DATA_BITS'(bt), CFG_DATA_BITS'(ct), CFG_DATA_BITS'(tt),
			CFG_DATA_BITS'(st)};
		for (int r = 0; r < 7; r++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[r];
			cfg_data  <= val[r];
			sb.set_reg(idx[r], val[r]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// a press followed by ticks: mostly run to the end and a little past it,
	// sometimes cut short so the next press restarts a running pattern
	task automatic pattern_run();
		logic [7:0] cmd;
		int         len;
		int         n;
		cmd = ($urandom_range(0, 7) < 6) ? 8'($urandom_range(0, 5))
			: 8'($urandom_range(0, 255));
		press(cmd, 7'($urandom_range(0, 100)));
		case (cmd)
			CMD_BATTERY:                        len = 12 * int'(sb.battery_ticks);
			CMD_CHECK:                          len = 7 * int'(sb.check_ticks);
			CMD_TRIPLE_WHITE, CMD_TRIPLE_GREEN: len = 6 * int'(sb.triple_ticks);
			default:                            len = int'(sb.single_ticks);
		endcase
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len)
			: len + $urandom_range(0, 3);
		// long step times: only a glimpse of the pattern
		if (n > 80)
			n = $urandom_range(1, 20);
		repeat (n) tick();
	endtask

	initial begin
		int  target;
		int  phase_start;
		bit  mid_done;
		int  pick;
		arst_n          <= 1'b0;
		in_valid        <= 1'b0;
		mode            <= 1'b0;
		command         <= '0;
		battery_percent <= '0;
		cfg_we          <= 1'b0;
		cfg_index       <= REG_FULL_THRESHOLD;
		cfg_data        <= '0;
		quiet   = 1'b0;
		idle_on = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: one-tick steps, so each tick moves a running pattern on by a step
		write_settings(90, 50, 20, 1, 1, 1, 1);
		tick();                               // tick while idle
		press(CMD_SINGLE_GREEN, 7'd0);
		tick();                               // single blink ends here
		tick();
		press(CMD_SINGLE_BLUE, 7'd0);
		press(CMD_OTHER_HIGH, 7'd100);        // unknown commands give red
		press(CMD_OTHER_LOW, 7'd0);
		tick();
		tick();
		// charge colour on each threshold and just below the full and low ones
		press(CMD_BATTERY, 7'd100);
		press(CMD_BATTERY, 7'd90);
		press(CMD_BATTERY, 7'd89);
		press(CMD_BATTERY, 7'd50);
		press(CMD_BATTERY, 7'd20);
		press(CMD_BATTERY, 7'd19);
		press(CMD_BATTERY, 7'd0);
		tick();
		tick();
		press(CMD_CHECK, 7'd0);
		tick();
		tick();
		press(CMD_TRIPLE_WHITE, 7'd0);
		tick();
		press(CMD_TRIPLE_GREEN, 7'd0);
		tick();
		tick();
		wait_results_drained();

		for (int phase = 1; phase <= 10; phase++) begin
			quiet   = (phase >= 9);
			idle_on = !quiet && ($urandom_range(0, 3) != 0);
			case (phase)
				1: write_settings(int'(FULL_THRESHOLD_RST), int'(MID_THRESHOLD_RST),
					int'(LOW_THRESHOLD_RST), int'(BATTERY_STEP_TICKS_RST),
					int'(CHECK_STEP_TICKS_RST), int'(TRIPLE_STEP_TICKS_RST),
					int'(SINGLE_ON_TICKS_RST));
				2: write_settings(100, 100, 100, 4095, 4095, 4095, 4095);
				3: write_settings(0, 0, 0, 1, 1, 1, 1);
				// thresholds out of order
				4: write_settings(10, 60, 95, $urandom_range(1, 4), $urandom_range(1, 4),
					$urandom_range(1, 4), $urandom_range(1, 4));
				default: write_settings($urandom_range(0, 100), $urandom_range(0, 100),
					$urandom_range(0, 100), $urandom_range(1, 6), $urandom_range(1, 6),
					$urandom_range(1, 6), $urandom_range(1, 6));
			endcase
			phase_start = sent;
			target      = sent + ((phase <= 2) ? 30 : 70);
			mid_done    = 1'b0;
			while (sent < target) begin
				if (!mid_done && sent >= phase_start + 25) begin
					mid_done = 1'b1;
					// pause until all is back, or let the result side hold off
					// while requests keep coming so the block backs up
					if (phase == 5)
						wait_results_drained();
					else if (phase == 6 || phase == 7)
						hold_off_now = 1'b1;
				end
				pick = $urandom_range(0, 9);
				if (pick < 7)
					pattern_run();
				else if (pick < 9)
					repeat ($urandom_range(1, 3)) tick();
				else
					press(8'($urandom_range(0, 255)), 7'($urandom_range(0, 100)));
			end
			wait_results_drained();
		end

		// let any stray result show up before the verdict
		repeat (8) @(posedge clk);
		sb.finish_check();
		$display("covered %0d requests and %0d lamp results over %0d register settings",
			sb.requests, sb.checked, settings_used);
		$display("including out-of-order thresholds, extreme step times and long hold-offs");
		if (sb.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/slps_pkg.sv
rtl/slps_cfg.sv
rtl/slps_step.sv
rtl/status_led_pattern_sequencer.sv
tb/tb.sv
